FILE: rtl/slrx_pkg.sv
// slrx_pkg: shared constants, types and the reply table of the slip receive deframer
// used by the front, queue, back and top rtl files of the block; depends on nothing
`default_nettype none

package slrx_pkg;

	localparam int MAX_FRAME_BYTES  = 1024;
	localparam int COMMAND_CAPACITY = 40;

	localparam int COUNT_W     = 11;
	localparam int CMD_LEN_W   = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int OK_LEN      = 4;
	localparam int REPLY_LEN   = 13;
	localparam int REPLY_IDX_W = 4;

	localparam logic [7:0] CODE_END     = 8'hC0;
	localparam logic [7:0] CODE_ESC     = 8'hDB;
	localparam logic [7:0] CODE_ESC_END = 8'hDC;
	localparam logic [7:0] CODE_ESC_ESC = 8'hDD;
	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_D       = 8'h44;
	localparam logic [7:0] CHAR_CR      = 8'h0D;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_REPLY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_END     = 2'd1,
		OP_OK      = 2'd2,
		OP_CONNECT = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         value;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// "OK\r\n" followed by "CONNECT\r\n"
	function automatic logic [7:0] reply_char(input logic [REPLY_IDX_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h4F;
			4'd1:    c = 8'h4B;
			4'd2:    c = 8'h0D;
			4'd3:    c = 8'h0A;
			4'd4:    c = 8'h43;
			4'd5:    c = 8'h4F;
			4'd6:    c = 8'h4E;
			4'd7:    c = 8'h4E;
			4'd8:    c = 8'h45;
			4'd9:    c = 8'h43;
			4'd10:   c = 8'h54;
			4'd11:   c = 8'h0D;
			4'd12:   c = 8'h0A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/slrx_in_if.sv
// slrx_in_if: valid/ready channel carrying one received serial byte per beat
// no dependencies
`default_nettype none

interface slrx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/slrx_out_if.sv
// slrx_out_if: valid/ready channel carrying one deframer result per beat
// no dependencies
`default_nettype none

interface slrx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [10:0] count;
	logic        last;

	modport source (output valid, output kind, output value, output count, output last,
		input ready);
	modport sink (input valid, input kind, input value, input count, input last,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/slrx_front.sv
// slrx_front: unescapes bytes, tracks frame and modem command state, emits queue entries
// depends on slrx_pkg and slrx_in_if
`default_nettype none

module slrx_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	slrx_in_if.sink        rx,
	input  wire logic      push_ready,
	output logic           push_valid,
	output slrx_pkg::entry_t push_entry
);

	logic                             escape_q;
	logic [slrx_pkg::COUNT_W-1:0]     frame_len_q;
	logic                             modem_q;
	logic [slrx_pkg::CMD_LEN_W-1:0]   cmd_len_q;
	logic [7:0]                       first_q;
	logic [7:0]                       third_q;

	logic                             escape_d;
	logic [slrx_pkg::COUNT_W-1:0]     frame_len_d;
	logic                             modem_d;
	logic [slrx_pkg::CMD_LEN_W-1:0]   cmd_len_d;
	logic [7:0]                       first_d;
	logic [7:0]                       third_d;

	logic                             accept;
	logic                             have;
	logic                             modem_eff;
	logic                             answer;
	logic [7:0]                       w;
	logic                             emit;
	slrx_pkg::entry_t                 entry;

	assign rx.ready = push_ready;
	assign accept   = rx.valid && push_ready;

	always_comb begin
		escape_d    = escape_q;
		frame_len_d = frame_len_q;
		modem_d     = modem_q;
		cmd_len_d   = cmd_len_q;
		first_d     = first_q;
		third_d     = third_q;
		w           = rx.rx_byte;
		have        = 1'b1;
		emit        = 1'b0;
		answer      = 1'b0;
		modem_eff   = modem_q;
		entry.op    = slrx_pkg::OP_BYTE;
		entry.value = 8'h00;
		entry.count = '0;

		if (escape_q) begin
			escape_d = 1'b0;
			if (rx.rx_byte == slrx_pkg::CODE_ESC_END) begin
				w = slrx_pkg::CODE_END;
			end else if (rx.rx_byte == slrx_pkg::CODE_ESC_ESC) begin
				w = slrx_pkg::CODE_ESC;
			end
		end else if (rx.rx_byte == slrx_pkg::CODE_ESC) begin
			escape_d = 1'b1;
			have     = 1'b0;
		end else if (rx.rx_byte == slrx_pkg::CODE_END) begin
			have = 1'b0;
			if (frame_len_q != '0) begin
				emit        = 1'b1;
				entry.op    = slrx_pkg::OP_END;
				entry.count = frame_len_q;
			end
			frame_len_d = '0;
			modem_d     = 1'b0;
		end

		if (have && frame_len_q == '0 && !modem_q) begin
			modem_eff = (w == slrx_pkg::CHAR_A) || (w == slrx_pkg::CHAR_PLUS);
			modem_d   = modem_eff;
		end

		if (have && modem_eff) begin
			answer = (w == slrx_pkg::CHAR_CR) ||
				(cmd_len_q == slrx_pkg::CMD_LEN_W'(3) && first_q == slrx_pkg::CHAR_PLUS);
			if (answer) begin
				emit = 1'b1;
				if (cmd_len_q >= slrx_pkg::CMD_LEN_W'(3) && third_q == slrx_pkg::CHAR_D) begin
					entry.op = slrx_pkg::OP_CONNECT;
				end else begin
					entry.op = slrx_pkg::OP_OK;
				end
				cmd_len_d = '0;
				first_d   = 8'h00;
				third_d   = 8'h00;
			end else if (cmd_len_q < slrx_pkg::CMD_LEN_W'(slrx_pkg::COMMAND_CAPACITY)) begin
				if (cmd_len_q == '0) begin
					first_d = w;
				end else if (cmd_len_q == slrx_pkg::CMD_LEN_W'(2)) begin
					third_d = w;
				end
				cmd_len_d = cmd_len_q + slrx_pkg::CMD_LEN_W'(1);
			end
		end else if (have && frame_len_q < slrx_pkg::COUNT_W'(slrx_pkg::MAX_FRAME_BYTES)) begin
			emit        = 1'b1;
			entry.op    = slrx_pkg::OP_BYTE;
			entry.value = w;
			entry.count = frame_len_q;
			frame_len_d = frame_len_q + slrx_pkg::COUNT_W'(1);
		end
	end

	assign push_valid = accept && emit;
	assign push_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q    <= 1'b0;
			frame_len_q <= '0;
			modem_q     <= 1'b0;
			cmd_len_q   <= '0;
			first_q     <= 8'h00;
			third_q     <= 8'h00;
		end else if (accept) begin
			escape_q    <= escape_d;
			frame_len_q <= frame_len_d;
			modem_q     <= modem_d;
			cmd_len_q   <= cmd_len_d;
			first_q     <= first_d;
			third_q     <= third_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slrx_queue.sv
// slrx_queue: small first-in first-out queue of entries between front and back
// depends on slrx_pkg
`default_nettype none

module slrx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire slrx_pkg::entry_t push_entry,
	output logic                  push_ready,
	output logic                  head_valid,
	output slrx_pkg::entry_t      head_entry,
	input  wire logic             pop
);

	slrx_pkg::entry_t               mem_q [slrx_pkg::QUEUE_DEPTH];
	logic [slrx_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [slrx_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [slrx_pkg::QCNT_W-1:0]    fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = fill_q != slrx_pkg::QCNT_W'(slrx_pkg::QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + slrx_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + slrx_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + slrx_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - slrx_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slrx_back.sv
// slrx_back: expands queue entries into result beats, spelling out modem replies
// depends on slrx_pkg and slrx_out_if
`default_nettype none

module slrx_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire slrx_pkg::entry_t head_entry,
	output logic                  pop,
	slrx_out_if.source            tx
);

	logic [slrx_pkg::REPLY_IDX_W-1:0] idx_q;
	logic                             valid_q;
	slrx_pkg::kind_t                  kind_q;
	logic [7:0]                       value_q;
	logic [slrx_pkg::COUNT_W-1:0]     count_q;
	logic                             last_q;

	logic                             load;
	logic                             final_beat;
	slrx_pkg::kind_t                  kind_d;
	logic [7:0]                       value_d;
	logic [slrx_pkg::COUNT_W-1:0]     count_d;

	assign load = head_valid && (!valid_q || tx.ready);
	assign pop  = load && final_beat;

	always_comb begin
		final_beat = 1'b1;
		kind_d     = slrx_pkg::KIND_REPLY;
		value_d    = slrx_pkg::reply_char(idx_q);
		count_d    = '0;
		case (head_entry.op)
			slrx_pkg::OP_BYTE: begin
				kind_d  = slrx_pkg::KIND_BYTE;
				value_d = head_entry.value;
				count_d = head_entry.count;
			end
			slrx_pkg::OP_END: begin
				kind_d  = slrx_pkg::KIND_END;
				value_d = 8'h00;
				count_d = head_entry.count;
			end
			slrx_pkg::OP_OK: begin
				final_beat = idx_q == slrx_pkg::REPLY_IDX_W'(slrx_pkg::OK_LEN - 1);
			end
			slrx_pkg::OP_CONNECT: begin
				final_beat = idx_q == slrx_pkg::REPLY_IDX_W'(slrx_pkg::REPLY_LEN - 1);
			end
			default: begin
				final_beat = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_beat ? '0 : idx_q + slrx_pkg::REPLY_IDX_W'(1);
			end else if (tx.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			count_q <= count_d;
			last_q  <= final_beat;
		end
	end

	assign tx.valid = valid_q;
	assign tx.kind  = kind_q;
	assign tx.value = value_q;
	assign tx.count = count_q;
	assign tx.last  = last_q;

endmodule

`default_nettype wire

FILE: rtl/slrx_rx_deframer_with_modem_replies.sv
// slip_rx_deframer_with_modem_replies: top level joining front, queue and back
// depends on slrx_pkg, slrx_in_if, slrx_out_if, slrx_front, slrx_queue, slrx_back
`default_nettype none

// Undoes SLIP framing on a stream of received bytes and answers modem commands.
// A byte is taken on every cycle while the four-entry queue between the front
// and the back has room; each byte causes at most one queue entry. The back
// sends one result beat per cycle while tx is ready, from a registered output
// stage: a data byte or end of frame is one beat, an OK reply four beats and an
// OK plus CONNECT reply thirteen beats, so long replies drain one character per
// cycle and hold the input off only once the queue has filled behind them.
module slip_rx_deframer_with_modem_replies (
	input  wire logic clk,
	input  wire logic arst_n,
	slrx_in_if.sink   rx,
	slrx_out_if.source tx
);

	logic             push_valid;
	logic             push_ready;
	slrx_pkg::entry_t push_entry;
	logic             head_valid;
	slrx_pkg::entry_t head_entry;
	logic             pop;

	slrx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	slrx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	slrx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

`default_nettype wire
